@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// In synthesis builds every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: condition violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check violated");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/pmenc_pkg.sv @@
`timescale 1ns / 1ps

package pmenc_pkg;

   // Field widths of the channels.
   localparam int MODE_W     = 2;
   localparam int RIC_W      = 21;
   localparam int FUNC_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int CODEWORD_W = 32;

   // Codeword layout: 21 information bits, 10 check bits, 1 parity bit.
   localparam int INFO_W  = 21;
   localparam int CHECK_W = 10;
   localparam int ACC_W   = 20;
   localparam int FILL_W  = 5;

   // Packing constants.
   localparam int DIGITS_PER_WORD = 5;
   localparam int ASCII_BITS      = 7;
   localparam int ADDR_SHIFT      = 3;

   // Short queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CODEWORD_W-1:0] BCH_POLY  = 32'hED200000;
   localparam logic [CODEWORD_W-1:0] IDLE_WORD = 32'h7A89C197;
   localparam logic [3:0]            BCD_SPACE = 4'h3;

   // Item modes.
   typedef enum logic [MODE_W-1:0] {
      MODE_START = 2'd0,
      MODE_CHAR  = 2'd1,
      MODE_END   = 2'd2
   } pmenc_mode_type;

   // Function codes.
   localparam logic [FUNC_W-1:0] FUNC_NUMERIC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALERT1  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ALERT2  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_ALPHA   = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [RIC_W-1:0]  ric;
      logic [FUNC_W-1:0] function_code;
      logic [CHAR_W-1:0] char_byte;
   } pmenc_req_type;

   typedef struct packed {
      logic [CODEWORD_W-1:0] codeword;
      logic                  last;
   } pmenc_rsp_type;

   // One pending codeword: information bits, or the idle word.
   typedef struct packed {
      logic [INFO_W-1:0] info;
      logic              idle;
      logic              last;
   } pmenc_job_type;

   // Up to two codewords pushed by one item.
   typedef struct packed {
      logic [1:0]    count;
      pmenc_job_type job0;
      pmenc_job_type job1;
   } pmenc_push_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               room;
      logic               nonempty;
   } pmenc_qstat_type;

   // BCH(31,21) check bits of a word whose low 11 bits are zero.
   function automatic logic [CHECK_W-1:0] bch_check(input logic [CODEWORD_W-1:0] word);
      logic [CODEWORD_W-1:0] rem;
      rem = word;
      for (int i = 0; i < INFO_W; i++) begin
         if (rem[CODEWORD_W-1]) begin
            rem = rem ^ BCH_POLY;
         end
         rem = rem << 1;
      end
      return rem[CODEWORD_W-1 -: CHECK_W];
   endfunction

   // Bit-reversed BCD code of a numeric character, with a hit flag on top.
   function automatic logic [4:0] numeric_code(input logic [CHAR_W-1:0] c);
      logic [4:0] result;
      unique case (c)
         "0": result = {1'b1, 4'h0};
         "1": result = {1'b1, 4'h8};
         "2": result = {1'b1, 4'h4};
         "3": result = {1'b1, 4'hC};
         "4": result = {1'b1, 4'h2};
         "5": result = {1'b1, 4'hA};
         "6": result = {1'b1, 4'h6};
         "7": result = {1'b1, 4'hE};
         "8": result = {1'b1, 4'h1};
         "9": result = {1'b1, 4'h9};
         "U": result = {1'b1, 4'hD};
         " ": result = {1'b1, 4'h3};
         "-": result = {1'b1, 4'hB};
         ")": result = {1'b1, 4'h7};
         "(": result = {1'b1, 4'hF};
         default: result = 5'b0;
      endcase
      return result;
   endfunction

endpackage

@@ src/pmenc_chan_if.sv @@
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload item per handshake.
interface pmenc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/pmenc_front.sv @@
`timescale 1ns / 1ps

// Front part: holds the message state, packs characters and pushes the
// codewords each item causes into the queue.
module pmenc_front
   import pmenc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  pmenc_req_type  req,
   output pmenc_push_type push
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic              odd_ff, odd_in;

   logic [4:0]                lookup;
   logic [ACC_W-1:0]          num_acc;
   logic [ASCII_BITS-1:0]     rev;
   logic [ACC_W+ASCII_BITS-1:0] ext;
   logic [FILL_W-1:0]         sum;
   logic [ACC_W-1:0]          pad;
   pmenc_job_type             msg_job, idle_job, addr_job;

   // Numeric lookup and the digit slot it lands in.
   always_comb begin
      lookup  = numeric_code(req.char_byte);
      num_acc = acc_ff;
      for (int d = 0; d < DIGITS_PER_WORD; d++) begin
         if (fill_ff == FILL_W'(d)) begin
            num_acc[ACC_W-1-4*d -: 4] = acc_ff[ACC_W-1-4*d -: 4] | lookup[3:0];
         end
      end
   end

   // ASCII bits go in LSB first, so the character is reversed before placing.
   always_comb begin
      for (int i = 0; i < ASCII_BITS; i++) begin
         rev[ASCII_BITS-1-i] = req.char_byte[i];
      end
      ext = {acc_ff, ASCII_BITS'(0)}
         | ((ACC_W+ASCII_BITS)'(rev) << (FILL_W'(ACC_W) - fill_ff));
      sum = fill_ff + FILL_W'(ASCII_BITS);
   end

   // BCD spaces for the digit slots still open at the end of a numeric message.
   always_comb begin
      pad = '0;
      for (int i = 0; i < DIGITS_PER_WORD; i++) begin
         if (FILL_W'(i) >= fill_ff) begin
            pad[ACC_W-1-4*i -: 4] = BCD_SPACE;
         end
      end
   end

   // Next state and pushed codewords.
   always_comb begin
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      func_in  = func_ff;
      odd_in   = odd_ff;
      push     = '0;
      addr_job = '{info: {1'b0, req.ric[RIC_W-1:ADDR_SHIFT], req.function_code},
                   idle: 1'b0, last: 1'b0};
      msg_job  = '{info: {1'b1, acc_ff}, idle: 1'b0, last: 1'b0};
      idle_job = '{info: '0, idle: 1'b1, last: 1'b1};
      if (accept) begin
         unique case (req.mode)
            MODE_START: begin
               push.count = 2'd1;
               push.job0  = addr_job;
               acc_in     = '0;
               fill_in    = '0;
               func_in    = req.function_code;
               odd_in     = 1'b1;
            end
            MODE_CHAR: begin
               if (func_ff == FUNC_NUMERIC) begin
                  if (lookup[4] && fill_ff < FILL_W'(DIGITS_PER_WORD)) begin
                     if (fill_ff == FILL_W'(DIGITS_PER_WORD - 1)) begin
                        push.count     = 2'd1;
                        push.job0.info = {1'b1, num_acc};
                        acc_in         = '0;
                        fill_in        = '0;
                        odd_in         = ~odd_ff;
                     end else begin
                        acc_in  = num_acc;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
               end else if (func_ff != FUNC_ALERT1) begin
                  if (sum >= FILL_W'(ACC_W)) begin
                     push.count     = 2'd1;
                     push.job0.info = {1'b1, ext[ACC_W+ASCII_BITS-1:ASCII_BITS]};
                     acc_in         = {ext[ASCII_BITS-1:0], (ACC_W-ASCII_BITS)'(0)};
                     fill_in        = sum - FILL_W'(ACC_W);
                     odd_in         = ~odd_ff;
                  end else begin
                     acc_in  = ext[ACC_W+ASCII_BITS-1:ASCII_BITS];
                     fill_in = sum;
                  end
               end
            end
            MODE_END: begin
               if (func_ff == FUNC_NUMERIC) begin
                  msg_job.info = {1'b1, acc_ff | pad};
               end
               if (fill_ff != '0) begin
                  if (odd_ff) begin
                     // The flush word makes the count even: it closes the message.
                     push.count = 2'd1;
                     push.job0  = msg_job;
                     push.job0.last = 1'b1;
                  end else begin
                     push.count = 2'd2;
                     push.job0  = msg_job;
                     push.job1  = idle_job;
                  end
               end else if (odd_ff) begin
                  push.count = 2'd1;
                  push.job0  = idle_job;
               end
               acc_in  = '0;
               fill_in = '0;
               odd_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         fill_ff <= '0;
         func_ff <= FUNC_NUMERIC;
         odd_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
         func_ff <= func_in;
         odd_ff  <= odd_in;
      end
   end

endmodule

@@ src/pmenc_queue.sv @@
`timescale 1ns / 1ps

// Short queue between front and back. It takes up to two entries per cycle
// and gives one.
module pmenc_queue
   import pmenc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pmenc_push_type  push,
   input  logic            pop,
   output pmenc_job_type   head,
   output pmenc_qstat_type stat
);

   pmenc_job_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + COUNT_W'(push.count) - COUNT_W'(pop);
   end

   assign head          = entry_ff[rd_ptr_ff];
   assign stat.count    = count_ff;
   assign stat.nonempty = (count_ff != '0);
   assign stat.room     = (count_ff <= COUNT_W'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.job0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.job1;
      end
   end

endmodule

@@ src/pmenc_back.sv @@
`timescale 1ns / 1ps

// Back part: adds BCH check bits and parity to the queue head and holds the
// finished codeword in the output register.
module pmenc_back
   import pmenc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pmenc_job_type       head,
   input  logic                head_valid,
   output logic                pop,
   pmenc_chan_if.source        rsp
);

   logic [CHECK_W-1:0]    syn_term [INFO_W];
   logic [CHECK_W-1:0]    check;
   logic [CODEWORD_W-1:0] word;
   logic                  valid_ff, valid_in;
   pmenc_rsp_type         out_ff, out_in;

   // The check bits are linear in the data: XOR of one syndrome per set bit.
   for (genvar j = 0; j < INFO_W; j++) begin : g_syn
      localparam logic [CHECK_W-1:0] SYN = bch_check(CODEWORD_W'(1) << (CHECK_W + 1 + j));
      assign syn_term[j] = head.info[j] ? SYN : '0;
   end

   always_comb begin
      check = '0;
      for (int j = 0; j < INFO_W; j++) begin
         check = check ^ syn_term[j];
      end
      word = {head.info, check, ^{head.info, check}};
   end

   // Load a new codeword whenever the output register is free or being taken.
   always_comb begin
      pop      = head_valid && (!valid_ff || rsp.ready);
      valid_in = valid_ff;
      out_in   = out_ff;
      if (!valid_ff || rsp.ready) begin
         valid_in = head_valid;
      end
      if (pop) begin
         out_in.codeword = head.idle ? IDLE_WORD : word;
         out_in.last     = head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp.valid   = valid_ff;
   assign rsp.payload = out_ff;

endmodule

@@ src/pocsag_message_encoder.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// POCSAG message encoder. A start item yields the address codeword, character
// items are packed into message codewords under the function of the last start,
// and an end item flushes the open word and adds an idle word when the message
// has an odd number of codewords, marking the last codeword it pushes, if any,
// with last. Items are taken one per cycle while the four-entry queue between
// the packing front and the BCH back has room for two entries; the back sends
// one codeword per cycle while the output is ready, so the flush word and the
// idle word of an end item go out one after the other. A codeword goes from its
// queue entry to the output register, and waits in the queue while the output stalls.
module pocsag_message_encoder
   import pmenc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pmenc_chan_if.sink   req_chan,
   pmenc_chan_if.source rsp_chan
);

   logic            accept;
   logic            start_accept;
   logic            pop;
   pmenc_push_type  push;
   pmenc_job_type   head;
   pmenc_qstat_type q_stat;

   assign req_chan.ready = q_stat.room;
   assign accept         = req_chan.valid && req_chan.ready;
   assign start_accept   = accept && (req_chan.payload.mode == MODE_START);

   pmenc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_chan.payload),
      .push   (push)
   );

   pmenc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (q_stat)
   );

   pmenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (q_stat.nonempty),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

   // The queue never holds more entries than it has.
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, q_stat.count <= COUNT_W'(QUEUE_DEPTH))

   // Every codeword sent, idle word included, has even parity.
   `ASSERT_ALWAYS(a_even_parity, clock, reset, !rsp_chan.valid || !(^rsp_chan.payload.codeword))

   // An accepted start item always leaves its address codeword queued.
   `ASSERT_NEXT(a_start_queued, clock, reset, start_accept, q_stat.nonempty)

endmodule

@@ bench/pocsag_message_encoder_test.sv @@
`timescale 1ns / 1ps

module pocsag_message_encoder_test;
   import pmenc_pkg::*;

   // The mode code that the block must ignore.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int RANDOM_ITEMS = 450;

   // Tracks the encoder state and the codewords still owed to the output.
   class pocsag_scoreboard;
      logic [ACC_W-1:0]  open_bits;
      logic [FILL_W-1:0] packed_count;
      logic [FUNC_W-1:0] latched_func;
      bit                odd_words;
      pmenc_rsp_type     owed_words[$];
      int                failures;

      function new();
         open_bits = '0;
         packed_count = '0;
         latched_func = FUNC_NUMERIC;
         odd_words = 1'b0;
         failures = 0;
      endfunction

      // Adds the BCH(31,21) check bits and the even parity bit.
      function automatic logic [CODEWORD_W-1:0] seal_codeword(logic [CODEWORD_W-1:0] info);
         logic [CODEWORD_W-1:0] rem;
         logic [CODEWORD_W-1:0] sealed;
         rem = info;
         for (int i = 0; i < 21; i++) begin
            if (rem[31]) begin
               rem = rem ^ BCH_POLY;
            end
            rem = rem << 1;
         end
         sealed = info | (rem >> 21);
         sealed[0] = ^sealed;
         return sealed;
      endfunction

      // Numeric characters map to BCD values sent with their bit order reversed.
      function automatic bit bcd_lookup(logic [CHAR_W-1:0] ch, output logic [3:0] code);
         logic [3:0] bcd;
         bit hit;
         hit = 1'b1;
         bcd = 4'h0;
         if (ch >= "0" && ch <= "9") begin
            bcd = 4'(ch - "0");
         end else if (ch == "U") begin
            bcd = 4'hB;
         end else if (ch == " ") begin
            bcd = 4'hC;
         end else if (ch == "-") begin
            bcd = 4'hD;
         end else if (ch == ")") begin
            bcd = 4'hE;
         end else if (ch == "(") begin
            bcd = 4'hF;
         end else begin
            hit = 1'b0;
         end
         code = {bcd[0], bcd[1], bcd[2], bcd[3]};
         return hit;
      endfunction

      function void owe_word(logic [CODEWORD_W-1:0] word);
         pmenc_rsp_type entry;
         entry.codeword = word;
         entry.last = 1'b0;
         owed_words = {owed_words, entry};
         odd_words = ~odd_words;
      endfunction

      function void owe_open_word();
         owe_word(seal_codeword({1'b1, open_bits, 11'b0}));
         open_bits = '0;
         packed_count = '0;
      endfunction

      // Works out the codewords that one accepted item causes.
      function void note_item(pmenc_req_type item);
         logic [3:0] code;
         pmenc_rsp_type tail;
         int owed_before;
         owed_before = owed_words.size();
         case (item.mode)
            MODE_START: begin
               open_bits = '0;
               packed_count = '0;
               latched_func = item.function_code;
               odd_words = 1'b0;
               owe_word(seal_codeword({1'b0, item.ric[RIC_W-1:ADDR_SHIFT],
                                       item.function_code, 11'b0}));
            end
            MODE_CHAR: begin
               if (latched_func == FUNC_NUMERIC) begin
                  if (bcd_lookup(item.char_byte, code)) begin
                     open_bits = open_bits | (ACC_W'(code) << (16 - 4 * int'(packed_count)));
                     packed_count++;
                     if (packed_count == DIGITS_PER_WORD) begin
                        owe_open_word();
                     end
                  end
               end else if (latched_func != FUNC_ALERT1) begin
                  // Seven bits, least significant first; a character may span two words.
                  for (int i = 0; i < ASCII_BITS; i++) begin
                     if (item.char_byte[i]) begin
                        open_bits[ACC_W - 1 - packed_count] = 1'b1;
                     end
                     packed_count++;
                     if (packed_count == ACC_W) begin
                        owe_open_word();
                     end
                  end
               end
            end
            MODE_END: begin
               if (packed_count != 0) begin
                  if (latched_func == FUNC_NUMERIC) begin
                     for (int i = int'(packed_count); i < DIGITS_PER_WORD; i++) begin
                        open_bits = open_bits | (ACC_W'(BCD_SPACE) << (16 - 4 * i));
                     end
                  end
                  owe_open_word();
               end
               if (odd_words) begin
                  owe_word(IDLE_WORD);
               end
               // The final codeword of this item closes the message.
               if (owed_words.size() > owed_before) begin
                  tail = owed_words[owed_words.size() - 1];
                  tail.last = 1'b1;
                  owed_words[owed_words.size() - 1] = tail;
               end
               open_bits = '0;
               packed_count = '0;
               odd_words = 1'b0;
            end
            default: begin
            end
         endcase
      endfunction

      // Compares one accepted codeword with the oldest one owed.
      function void check_codeword(pmenc_rsp_type got);
         pmenc_rsp_type want;
         if (owed_words.size() == 0) begin
            $display("%0t: unexpected codeword %h last %b", $time, got.codeword, got.last);
            failures++;
            return;
         end
         want = owed_words[0];
         owed_words.delete(0);
         if (got.codeword !== want.codeword) begin
            $display("%0t: codeword mismatch, expected %h, actual %h",
                     $time, want.codeword, got.codeword);
            failures++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last mismatch on %h, expected %b, actual %b",
                     $time, want.codeword, want.last, got.last);
            failures++;
         end
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function void check_drained();
         if (owed_words.size() != 0) begin
            $display("%0t: %0d codewords never arrived, oldest expected %h",
                     $time, owed_words.size(), owed_words[0].codeword);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pmenc_chan_if #(.payload_type(pmenc_req_type)) req_chan ();
   pmenc_chan_if #(.payload_type(pmenc_rsp_type)) rsp_chan ();

   pocsag_message_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pocsag_scoreboard board = new();
   bit holdoff_request = 1'b0;
   int burst_left = 0;
   int counted_items = 0;
   string numeric_chars = "0123456789U -)(";

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one item in bursts with random gaps and waits for its handshake.
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [RIC_W-1:0] ric,
                            input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch);
      pmenc_req_type item;
      int gap;
      item.mode = mode;
      item.ric = ric;
      item.function_code = func;
      item.char_byte = ch;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      board.note_item(item);
      counted_items++;
   endtask

   // Stops offering items until every owed codeword has come out.
   task automatic wait_for_drain();
      int guard;
      guard = 0;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Result side: ready follows a changing stall pattern, with one long hold-off.
   initial begin
      int style;
      int span;
      int tick;
      rsp_chan.ready = 1'b0;
      tick = 0;
      forever begin
         style = $urandom_range(0, 3);
         span = $urandom_range(8, 40);
         repeat (span) begin
            @(negedge clock);
            if (holdoff_request) begin
               holdoff_request = 1'b0;
               rsp_chan.ready <= 1'b0;
               repeat (HOLDOFF_CYCLES) @(negedge clock);
            end
            tick++;
            case (style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (tick % 3 == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 99) < 85);
            endcase
         end
      end
   end

   // Every accepted codeword is checked at the clock edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_codeword(rsp_chan.payload);
      end
   end

   // Stimulus: a directed opening, then random messages.
   initial begin
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] ch;
      int pick;
      int length;
      int messages;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Ignored mode, an empty end, and a numeric character without a start, closed by an end.
      send_item(MODE_UNUSED, '1, '1, '1);
      send_item(MODE_END, '0, '0, '0);
      send_item(MODE_CHAR, '0, '0, "7");
      send_item(MODE_END, '0, '0, '0);

      // Numeric message: every special character, one byte outside the table.
      send_item(MODE_START, '0, FUNC_NUMERIC, '0);
      for (int i = 10; i < numeric_chars.len(); i++) begin
         send_item(MODE_CHAR, '0, '0, numeric_chars[i]);
      end
      send_item(MODE_CHAR, '0, '0, "A");
      send_item(MODE_END, '0, '0, '0);

      // Alphanumeric message at the largest address, a character spans two words.
      send_item(MODE_START, '1, FUNC_ALPHA, '0);
      send_item(MODE_CHAR, '0, '0, 8'hFF);
      send_item(MODE_CHAR, '0, '0, 8'h80);
      send_item(MODE_CHAR, '0, '0, 8'h00);
      send_item(MODE_END, '0, '0, '0);

      // Alert one ignores its characters.
      send_item(MODE_START, 21'h0AAAAA, FUNC_ALERT1, '0);
      send_item(MODE_CHAR, '0, '0, "x");
      send_item(MODE_END, '0, '0, '0);

      // A start in the middle of a message drops its open word.
      send_item(MODE_START, 21'h155555, FUNC_ALERT2, '0);
      send_item(MODE_CHAR, '0, '0, "P");
      send_item(MODE_START, 21'h012345, FUNC_NUMERIC, '0);
      send_item(MODE_CHAR, '0, '0, "0");
      send_item(MODE_END, '0, '0, '0);
      wait_for_drain();

      // Random messages, mostly well formed, with some stray items.
      messages = 0;
      while (counted_items < RANDOM_ITEMS) begin
         messages++;
         if (messages == 6) begin
            holdoff_request = 1'b1;
         end
         if (messages == 14) begin
            wait_for_drain();
         end
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_item(MODE_UNUSED, RIC_W'($urandom), FUNC_W'($urandom), CHAR_W'($urandom));
         end else if (pick < 10) begin
            send_item(($urandom_range(0, 1) == 0) ? MODE_CHAR : MODE_END,
                      RIC_W'($urandom), FUNC_W'($urandom), CHAR_W'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               func = FUNC_NUMERIC;
            end else if (pick < 70) begin
               func = FUNC_ALPHA;
            end else if (pick < 85) begin
               func = FUNC_ALERT2;
            end else begin
               func = FUNC_ALERT1;
            end
            send_item(MODE_START, RIC_W'($urandom), func, CHAR_W'($urandom));
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48)
                                                  : $urandom_range(0, 12);
            repeat (length) begin
               if (func == FUNC_NUMERIC && $urandom_range(0, 9) != 0) begin
                  ch = numeric_chars[$urandom_range(0, 14)];
               end else begin
                  ch = CHAR_W'($urandom);
               end
               send_item(MODE_CHAR, RIC_W'($urandom), FUNC_W'($urandom), ch);
            end
            // Now and then the message is left open for the next start to drop.
            if ($urandom_range(0, 9) != 0) begin
               send_item(MODE_END, RIC_W'($urandom), FUNC_W'($urandom), CHAR_W'($urandom));
            end
         end
      end

      // Let the last codewords come out, then wait quietly before the final check.
      wait_for_drain();
      repeat (10) @(posedge clock);
      board.check_drained();
      if (board.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ pocsag_message_encoder.f @@
+incdir+src
src/pmenc_pkg.sv
src/pmenc_chan_if.sv
src/pmenc_front.sv
src/pmenc_queue.sv
src/pmenc_back.sv
src/pocsag_message_encoder.sv
bench/pocsag_message_encoder_test.sv
